### design/ptw_pkg.sv
// Shared types, constants and helper functions of the page table walk engine.
// Used by every module of the block but ptw_ram; depends on nothing else.
package ptw_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int TABLE_ENTRIES = 512;
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] EMPTY_MARK = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PAGE_OFFSET_MASK = 64'h0000_0000_0000_0FFF;
  localparam logic [63:0] NEW_TABLE_ATTR = 64'h0000_0000_0000_0007;
  localparam logic [63:0] FLAG_MASK_RESET = 64'h0000_0000_0000_0FFF;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ = 3'd1,
    OP_FREE = 3'd2,
    OP_ALLOC = 3'd3,
    OP_WALK = 3'd4,
    OP_MAP = 3'd5,
    OP_SETFLAGS = 3'd6,
    OP_NOP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ABSENT = 2'd1,
    ST_NOFREE = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_POPWAIT,
    S_WALK,
    S_WDATA,
    S_WPOP,
    S_LEAF
  } state_e;

  // Decoded command handed from the front part to the back part.
  typedef struct packed {
    op_e          op;
    logic [19:0]  addr0;   // root plus top-level entry offset
    logic [47:0]  vaddr;
    logic [1:0]   target;  // level at which the walk stops
    logic         create;  // missing tables are allocated
    logic [18:0]  pa;
    logic [63:0]  value;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic in_range(input logic [63:0] a);
    return (a >> 3) < 64'(MEM_WORDS);
  endfunction

  function automatic logic [IDX_W-1:0] level_index(input logic [47:0] va,
                                                   input logic [1:0] k);
    logic [IDX_W-1:0] r;
    case (k)
      2'd0: r = va[47:39];
      2'd1: r = va[38:30];
      2'd2: r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

### design/ptw_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### design/ptw_front.sv
// Front part: accepts input transfers, decodes them and queues the commands.
// Depends on ptw_pkg.
module ptw_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            in_op_i,
  input  logic [18:0]           in_root_i,
  input  logic [47:0]           in_vaddr_i,
  input  logic [1:0]            in_level_i,
  input  logic [18:0]           in_pa_i,
  input  logic [63:0]           in_value_i,
  input  ptw_pkg::back_status_t back_status_i,
  output logic                  cmd_valid_o,
  output ptw_pkg::cmd_t         cmd_o,
  input  logic                  cmd_pop_i
);
  import ptw_pkg::*;

  cmd_t                queue_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  cmd_t                dec;
  logic                push, pop;

  always_comb begin
    dec.op     = op_e'(in_op_i);
    dec.addr0  = {1'b0, in_root_i} + {8'd0, level_index(in_vaddr_i, 2'd0), 3'b000};
    dec.vaddr  = in_vaddr_i;
    dec.target = (op_e'(in_op_i) == OP_WALK) ? in_level_i : 2'd3;
    dec.create = (op_e'(in_op_i) == OP_MAP) || (op_e'(in_op_i) == OP_SETFLAGS);
    dec.pa     = in_pa_i;
    dec.value  = in_value_i;
  end

  assign in_ready_o  = !back_status_i.clearing && (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = count_q != '0;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> count_q != '0) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("count slip");

endmodule

### design/ptw_back.sv
// Back part: sequencer that carries out queued commands on the word memory.
// Depends on ptw_pkg and ptw_ram.
module ptw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [63:0]           cfg_wdata_i,
  input  logic                  cmd_valid_i,
  input  ptw_pkg::cmd_t         cmd_i,
  output logic                  cmd_pop_o,
  output ptw_pkg::back_status_t back_status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           out_value_o,
  output logic [1:0]            out_status_o
);
  import ptw_pkg::*;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [63:0]       a_q, a_d;
  logic [2:0]        k_q, k_d;
  logic [63:0]       head_q, head_d;
  logic [63:0]       mask_q;
  logic [MEM_AW-1:0] clr_q, clr_d;
  logic              ov_q, ov_d;
  logic [63:0]       res_q, res_d;
  status_e           st_q, st_d;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [63:0]       ram_wdata, ram_rdata;
  logic [63:0]       next_a;

  ptw_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign back_status_o.clearing = (state_q == S_CLEAR);
  assign out_valid_o  = ov_q;
  assign out_value_o  = res_q;
  assign out_status_o = st_q;
  assign next_a = (ram_rdata & ~PAGE_OFFSET_MASK)
                + {52'd0, level_index(cmd_q.vaddr, k_q[1:0]), 3'b000};

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    a_d       = a_q;
    k_d       = k_q;
    head_d    = head_q;
    clr_d     = clr_q;
    ov_d      = ov_q && !out_ready_i;
    res_d     = res_q;
    st_d      = st_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = a_q[MEM_AW+2:3];
    ram_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == MEM_AW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && !ov_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = '0;
          st_d      = ST_OK;
          ram_addr  = cmd_i.pa[MEM_AW+2:3];
          unique case (cmd_i.op)
            OP_WRITE: begin
              ram_we    = 1'b1;
              ram_wdata = cmd_i.value;
              ov_d      = 1'b1;
            end
            OP_READ: state_d = S_RDATA;
            OP_FREE: begin
              ram_we    = 1'b1;
              ram_wdata = head_q;
              head_d    = {45'd0, cmd_i.pa};
              ov_d      = 1'b1;
            end
            OP_ALLOC: begin
              ram_addr = head_q[MEM_AW+2:3];
              if (head_q == EMPTY_MARK) begin
                st_d = ST_NOFREE;
                ov_d = 1'b1;
              end else if (!in_range(head_q)) begin
                st_d = ST_RANGE;
                ov_d = 1'b1;
              end else begin
                state_d = S_POPWAIT;
              end
            end
            OP_WALK, OP_MAP, OP_SETFLAGS: begin
              a_d     = {44'd0, cmd_i.addr0};
              k_d     = 3'd1;
              state_d = S_WALK;
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      S_RDATA: begin
        res_d   = ram_rdata;
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end
      S_POPWAIT: begin
        head_d  = ram_rdata;
        res_d   = head_q;
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK: begin
        if (!in_range(a_q)) begin
          st_d    = ST_RANGE;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end else if (k_q > {1'b0, cmd_q.target}) begin
          // Walk complete: a_q is the entry address at the target level.
          unique case (cmd_q.op)
            OP_MAP: begin
              ram_we    = 1'b1;
              ram_wdata = {45'd0, cmd_q.pa} | cmd_q.value;
              res_d     = a_q;
              ov_d      = 1'b1;
              state_d   = S_IDLE;
            end
            OP_SETFLAGS: state_d = S_LEAF;
            default: begin
              res_d   = a_q;
              ov_d    = 1'b1;
              state_d = S_IDLE;
            end
          endcase
        end else begin
          state_d = S_WDATA;
        end
      end
      S_WDATA: begin
        if (ram_rdata[0]) begin
          a_d     = next_a;
          k_d     = k_q + 1'b1;
          state_d = S_WALK;
        end else if (!cmd_q.create) begin
          st_d    = ST_ABSENT;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end else if (head_q == EMPTY_MARK) begin
          st_d    = ST_NOFREE;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end else if (!in_range(head_q)) begin
          st_d    = ST_RANGE;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_addr = head_q[MEM_AW+2:3];
          state_d  = S_WPOP;
        end
      end
      S_WPOP: begin
        // Link the popped page as a new table; its contents are left as found.
        head_d    = ram_rdata;
        ram_we    = 1'b1;
        ram_wdata = head_q | NEW_TABLE_ATTR;
        a_d       = (head_q & ~PAGE_OFFSET_MASK)
                  + {52'd0, level_index(cmd_q.vaddr, k_q[1:0]), 3'b000};
        k_d       = k_q + 1'b1;
        state_d   = S_WALK;
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & ~mask_q) | cmd_q.value;
        res_d     = a_q;
        ov_d      = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      head_q  <= EMPTY_MARK;
      mask_q  <= FLAG_MASK_RESET;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    a_q   <= a_d;
    res_q <= res_d;
    st_q  <= st_d;
  end

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !ov_q) else $error("result during clearing pass");
  a_wdata_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WDATA) |-> $past(state_q) == S_WALK) else $error("entry read out of order");
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> k_q <= 3'd4) else $error("walk level overrun");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE) && !ov_q) else $error("pop while busy");

endmodule

### design/page_table_walk_and_map_engine.sv
// Top level of the four-level page table walk and map engine.
// Depends on ptw_pkg, ptw_front, ptw_back and ptw_ram.
//
// The engine owns a 65536-word, 64-bit memory that holds page tables and a
// free-page stack linked through the pages. After reset a clearing pass zeroes
// the memory, one word a cycle; no input transfer is taken until it ends. Each
// accepted transfer gives one result transfer. The back sequencer makes one
// memory access per cycle with registered read data: a walk reads one entry
// per level, and each table allocated on the way pops a page from the free
// stack. A four-entry command queue lets inputs be taken while the sequencer
// is busy or a result is waiting.
module page_table_walk_and_map_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [18:0] root, [66:19] vaddr, [68:67] level, [87:69] phys_addr,
  // [151:88] value
  input  logic [151:0] s_axis_tdata,
  // [2:0] op
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] result_value, [65:64] status, [71:66] zero
  output logic [71:0]  m_axis_tdata
);
  import ptw_pkg::*;

  back_status_t bstat;
  cmd_t         cmd;
  logic         cmd_valid, cmd_pop;
  logic [63:0]  res;
  logic [1:0]   st;

  ptw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_root_i    (s_axis_tdata[18:0]),
    .in_vaddr_i   (s_axis_tdata[66:19]),
    .in_level_i   (s_axis_tdata[68:67]),
    .in_pa_i      (s_axis_tdata[87:69]),
    .in_value_i   (s_axis_tdata[151:88]),
    .back_status_i(bstat),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  ptw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .back_status_o(bstat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (res),
    .out_status_o (st)
  );

  assign m_axis_tdata = {6'd0, st, res};

endmodule
